// ===== rtl/string_replace_stream_top_macros.svh =====
// Assertion macros for the RTL of the string replace stream.
// Each macro takes a label, an antecedent and a consequent, all sampled on i_clk
// and disabled while i_rst_n is low.
`ifndef STRING_REPLACE_STREAM_TOP_MACROS_SVH
`define STRING_REPLACE_STREAM_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define SRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("string replace stream: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("string replace stream: next-cycle check failed");

`else

`define SRS_ASSERT_SAME(label, ante, cons)
`define SRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/srs_pkg.sv =====
`timescale 1ns / 1ps

package srs_pkg;

    localparam int MAX_PATTERN  = 8;
    localparam int MAX_REPL     = 8;
    localparam int BYTE_W       = 8;
    localparam int CFG_W        = 64;
    localparam int LEN_W        = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int BUNDLE_DEPTH = (MAX_PATTERN > MAX_REPL) ? MAX_PATTERN : MAX_REPL;
    localparam int WIN_CNT_W    = $clog2(MAX_PATTERN + 1);
    localparam int BCNT_W       = $clog2(BUNDLE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 8'd0,
        CFG_PATTERN_LENGTH     = 8'd1,
        CFG_REPLACEMENT_BYTES  = 8'd2,
        CFG_REPLACEMENT_LENGTH = 8'd3
    } t_cfg_idx;

    typedef logic [BYTE_W-1:0] t_byte;

    // Words produced by one input item, oldest in entry 0.
    typedef struct packed {
        t_byte [BUNDLE_DEPTH-1:0] bytes;
        logic [BCNT_W-1:0]        words;
        logic                     last;
        logic                     nobyte;
    } t_bundle;

endpackage

// ===== rtl/srs_window.sv =====
`timescale 1ns / 1ps

module srs_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  srs_pkg::t_byte               i_in_byte,
    input  logic                         i_byte_present,
    input  logic                         i_end_of_input,
    input  logic [srs_pkg::CFG_W-1:0]    i_pattern,
    input  logic [srs_pkg::WIN_CNT_W-1:0] i_plen,
    input  logic [srs_pkg::CFG_W-1:0]    i_repl,
    input  logic [srs_pkg::BCNT_W-1:0]   i_rlen,
    output srs_pkg::t_bundle             o_bundle
);
    import srs_pkg::*;

    t_byte [MAX_PATTERN-1:0] r_win;
    logic [WIN_CNT_W-1:0]    r_cnt;
    t_byte [MAX_PATTERN-1:0] n_win;
    logic [WIN_CNT_W-1:0]    n_cnt;

    t_byte [MAX_PATTERN-1:0] w_app;
    t_byte [MAX_PATTERN-1:0] w_drop;
    logic [WIN_CNT_W-1:0]    c_app;
    logic                    same;
    logic                    full;
    logic                    hit;
    logic                    emit;
    logic [BCNT_W-1:0]       words;

    always_comb begin
        // Append the new byte behind the held ones.
        w_app = r_win;
        c_app = r_cnt;
        if (i_byte_present && (r_cnt < WIN_CNT_W'(MAX_PATTERN))) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (WIN_CNT_W'(i) == r_cnt) begin
                    w_app[i] = i_in_byte;
                end
            end
            c_app = r_cnt + 1'b1;
        end

        same = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((WIN_CNT_W'(i) < i_plen) && (w_app[i] != i_pattern[i*BYTE_W +: BYTE_W])) begin
                same = 1'b0;
            end
        end
        full = (c_app == i_plen) && (i_plen != '0);
        hit  = i_byte_present && full && same;
        emit = i_byte_present && !hit && (full || (c_app > i_plen));

        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            w_drop[i] = w_app[i+1];
        end
        w_drop[MAX_PATTERN-1] = '0;

        if (hit || i_end_of_input) begin
            n_win = w_app;
            n_cnt = '0;
        end else if (emit) begin
            n_win = w_drop;
            n_cnt = c_app - 1'b1;
        end else begin
            n_win = w_app;
            n_cnt = c_app;
        end

        // On a match the replacement goes out; otherwise a prefix of the window
        // (the oldest byte, or all of it when the string ends).
        for (int i = 0; i < BUNDLE_DEPTH; i++) begin
            if (hit) begin
                o_bundle.bytes[i] = (i < MAX_REPL) ? i_repl[i*BYTE_W +: BYTE_W] : '0;
            end else begin
                o_bundle.bytes[i] = (i < MAX_PATTERN) ? w_app[i] : '0;
            end
        end

        if (hit) begin
            words = i_rlen;
        end else if (i_end_of_input) begin
            words = BCNT_W'(c_app);
        end else begin
            words = emit ? BCNT_W'(1) : '0;
        end

        o_bundle.last   = i_end_of_input;
        o_bundle.nobyte = i_end_of_input && (words == '0);
        o_bundle.words  = o_bundle.nobyte ? BCNT_W'(1) : words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== rtl/string_replace_stream_top.sv =====
`timescale 1ns / 1ps
// Streaming find-and-replace. Source bytes enter on the input channel
// (i_valid / o_ready) with i_byte_present and i_end_of_input; rewritten bytes
// leave on the output channel (o_valid / i_ready). Every non-overlapping
// occurrence of the pattern, scanned left to right, is replaced by the
// replacement text; other bytes pass through after a delay of up to the
// pattern length minus one bytes, which the match window holds back.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// pattern bytes, pattern length, replacement bytes and replacement length by
// index; write it only while the block is idle.
// The first word caused by an input word appears in the cycle after that word is
// accepted. Throughput: one input word per cycle while each input word causes at
// most one output word and the receiver is ready. A match or the end of a string
// can cause up to eight output words; they drain from an output shift register
// one per cycle while the receiver is ready, and the input is held off until its
// last word is being taken, except that input words that cause no output keep flowing.
// When the receiver stalls, the current output word holds steady.
// Reset empties the window and the output register and clears all
// configuration registers, which leaves the block in pass-through mode.
// A string that ends with no byte left to send closes with one end-only word.

module string_replace_stream_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_byte_present,
    input  logic                          i_end_of_input,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_out_present,
    output logic                          o_end_of_output
);
    import srs_pkg::*;

    `include "string_replace_stream_top_macros.svh"

    // Configuration registers.
    logic [CFG_W-1:0] r_pattern;
    logic [LEN_W-1:0] r_plen;
    logic [CFG_W-1:0] r_repl;
    logic [LEN_W-1:0] r_rlen;

    logic [WIN_CNT_W-1:0] plen_eff;
    logic [BCNT_W-1:0]    rlen_eff;

    // Output shift register: the word at entry 0 is on the output port.
    t_byte [BUNDLE_DEPTH-1:0] r_bytes;
    logic [BCNT_W-1:0]        r_left;
    logic                     r_last;
    logic                     r_nobyte;
    t_byte [BUNDLE_DEPTH-1:0] n_bytes;
    logic [BCNT_W-1:0]        n_left;
    logic                     n_last;
    logic                     n_nobyte;

    t_bundle bundle;
    logic    in_fire;
    logic    take;
    logic    load;
    logic    out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES:      r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen    <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_repl    <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lengths above the supported maximum count as the maximum.
    assign plen_eff = (r_plen > LEN_W'(MAX_PATTERN)) ? WIN_CNT_W'(MAX_PATTERN)
                                                     : WIN_CNT_W'(r_plen);
    assign rlen_eff = (r_rlen > LEN_W'(MAX_REPL)) ? BCNT_W'(MAX_REPL) : BCNT_W'(r_rlen);

    srs_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (in_fire),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_input (i_end_of_input),
        .i_pattern      (r_pattern),
        .i_plen         (plen_eff),
        .i_repl         (r_repl),
        .i_rlen         (rlen_eff),
        .o_bundle       (bundle)
    );

    // The output register can take a new bundle when it is empty or its last
    // word leaves this cycle. A word that produces nothing never needs it.
    assign take     = o_valid && i_ready;
    assign out_free = (r_left == '0) || ((r_left == BCNT_W'(1)) && i_ready);
    assign o_ready  = out_free || (bundle.words == '0);
    assign in_fire  = i_valid && o_ready;
    assign load     = in_fire && (bundle.words != '0);

    always_comb begin
        n_bytes  = r_bytes;
        n_left   = r_left;
        n_last   = r_last;
        n_nobyte = r_nobyte;
        if (load) begin
            n_bytes  = bundle.bytes;
            n_left   = bundle.words;
            n_last   = bundle.last;
            n_nobyte = bundle.nobyte;
        end else if (take) begin
            for (int i = 0; i < BUNDLE_DEPTH - 1; i++) begin
                n_bytes[i] = r_bytes[i+1];
            end
            n_bytes[BUNDLE_DEPTH-1] = '0;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_last   <= 1'b0;
            r_nobyte <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_last   <= n_last;
            r_nobyte <= n_nobyte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_valid         = (r_left != '0);
    assign o_out_byte      = r_nobyte ? '0 : r_bytes[0];
    assign o_out_present   = !r_nobyte;
    assign o_end_of_output = r_last && (r_left == BCNT_W'(1));

    // A new bundle never overwrites words that have not been delivered.
    `SRS_ASSERT_SAME(a_no_overwrite, load, (r_left == '0) || ((r_left == BCNT_W'(1)) && i_ready))
    // Taking a word that is not the last of its bundle leaves the next one valid.
    `SRS_ASSERT_NEXT(a_drain_continues, take && (r_left > BCNT_W'(1)), o_valid)
    // An end-only word carries a zero byte and closes the string.
    `SRS_ASSERT_SAME(a_end_only_word, o_valid && !o_out_present,
                     o_end_of_output && (o_out_byte == '0))

endmodule
